>>> design/binary_morphology_3x3_core_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion with an
// asynchronous active-low reset disable.
`ifndef BINARY_MORPHOLOGY_3X3_CORE_ASSERT_SVH
`define BINARY_MORPHOLOGY_3X3_CORE_ASSERT_SVH

// Same-cycle implication.
`define BM3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BM3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bm3_pkg.sv
`default_nettype none

package bm3_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  // Wide enough for row/column positions including the two drain rows.
  localparam int POS_W = 13;

  // Line buffer entry: classes of the two previous rows at one column.
  localparam int LINE_W = 4;

  localparam int CLS_ABOVE_BIT = 0;
  localparam int CLS_BELOW_BIT = 1;

  localparam logic [7:0] FG_RED   = 8'd252;
  localparam logic [7:0] FG_GREEN = 8'd210;
  localparam logic [7:0] FG_BLUE  = 8'd245;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_MORPH_MODE,
    REG_BRIGHT_THRESHOLD
  } reg_idx_e;

  typedef enum logic {
    CMD_PIXEL,
    CMD_DRAIN
  } cmd_e;

  typedef enum logic {
    MODE_DILATE,
    MODE_ERODE
  } mode_e;

  // Which stored columns form the left/center/right of the window.
  typedef enum logic [1:0] {
    WIN_ROW_START,
    WIN_COL_ONE,
    WIN_INNER
  } win_sel_e;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [11:0] frame_height;
    logic        morph_mode;
    logic [7:0]  bright_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:      11'd640,
    frame_height:     12'd480,
    morph_mode:       1'b0,
    bright_threshold: 8'd127
  };

  // Stage register contents handed from the scan logic to the window logic.
  typedef struct packed {
    logic       pix;
    logic       emit;
    logic       last;
    logic       top_clamp;
    logic       bot_clamp;
    win_sel_e   sel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stage_t;

  // One column of the 3x3 window, two class bits per row.
  typedef struct packed {
    logic [1:0] top;
    logic [1:0] mid;
    logic [1:0] bot;
  } col_cls_t;

  function automatic logic [1:0] bright_class(input logic [7:0] r,
                                              input logic [7:0] g,
                                              input logic [7:0] b,
                                              input logic [7:0] thr);
    logic [7:0] br;
    logic [1:0] cls;
    br = (r > g) ? r : g;
    if (b > br) br = b;
    cls = '0;
    cls[CLS_ABOVE_BIT] = (br > thr);
    cls[CLS_BELOW_BIT] = (br < thr);
    return cls;
  endfunction

endpackage

`default_nettype wire

>>> design/bm3_ram.sv
`default_nettype none

module bm3_ram #(
  parameter int Width = 4,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/bm3_cfg.sv
`default_nettype none

module bm3_cfg
  import bm3_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:      cfg_d.frame_width      = pwdata[10:0];
        REG_FRAME_HEIGHT:     cfg_d.frame_height     = pwdata[11:0];
        REG_MORPH_MODE:       cfg_d.morph_mode       = pwdata[0];
        REG_BRIGHT_THRESHOLD: cfg_d.bright_threshold = pwdata[7:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:      prdata = PDATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:     prdata = PDATA_W'(cfg_q.frame_height);
      REG_MORPH_MODE:       prdata = PDATA_W'(cfg_q.morph_mode);
      REG_BRIGHT_THRESHOLD: prdata = PDATA_W'(cfg_q.bright_threshold);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/bm3_scan.sv
`default_nettype none

module bm3_scan
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int ColW = $clog2(MAX_WIDTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            cmd_i,
  input  wire logic [7:0]      red_in_i,
  input  wire logic [7:0]      green_in_i,
  input  wire logic [7:0]      blue_in_i,
  input  wire logic            adv_i,
  output logic                 stage_valid_o,
  output stage_t               stage_o,
  output logic      [ColW-1:0] stage_col_o,
  output logic                 ram_re_o,
  output logic      [ColW-1:0] ram_raddr_o
);

  logic [10:0]      eff_w;
  logic [11:0]      eff_h;
  logic [POS_W-1:0] row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             stage_valid_q, stage_valid_d;
  stage_t           stage_q, stage_d;
  logic [ColW-1:0]  stage_col_q;
  logic             accept, live, row_done, input_done, last_hit, emit;

  always_comb begin
    eff_w = cfg_i.frame_width;
    if (cfg_i.frame_width < 11'd3) begin
      eff_w = 11'd3;
    end else if (POS_W'(cfg_i.frame_width) > POS_W'(MAX_WIDTH)) begin
      eff_w = 11'(MAX_WIDTH);
    end
    eff_h = (cfg_i.frame_height < 12'd3) ? 12'd3 : cfg_i.frame_height;
  end

  // Rows at or past the frame height are virtual: drains walk through
  // them so the trailing row plus one pixel of results can leave.
  assign input_done = (row_q >= POS_W'(eff_h));
  assign last_hit   = (row_q == POS_W'(eff_h) + POS_W'(1));
  assign row_done   = (POS_W'(col_q) + POS_W'(1) >= POS_W'(eff_w));
  assign live       = (cmd_i == CMD_DRAIN) ? input_done : !input_done;
  assign emit       = (col_q == '0) ? (row_q >= POS_W'(2)) : (row_q >= POS_W'(1));

  assign in_ready_o = !stage_valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept && live) begin
      if (last_hit) begin
        row_d = '0;
        col_d = '0;
      end else if (row_done) begin
        row_d = row_q + POS_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    if (accept) begin
      stage_valid_d = live;
    end else if (adv_i) begin
      stage_valid_d = 1'b0;
    end else begin
      stage_valid_d = stage_valid_q;
    end
  end

  always_comb begin
    stage_d.pix       = (cmd_i == CMD_PIXEL);
    stage_d.emit      = emit;
    stage_d.last      = last_hit;
    stage_d.top_clamp = (row_q == POS_W'(1));
    stage_d.bot_clamp = (cmd_i == CMD_DRAIN);
    if (col_q == '0) begin
      stage_d.sel = WIN_ROW_START;
    end else if (col_q == ColW'(1)) begin
      stage_d.sel = WIN_COL_ONE;
    end else begin
      stage_d.sel = WIN_INNER;
    end
    stage_d.red   = red_in_i;
    stage_d.green = green_in_i;
    stage_d.blue  = blue_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q         <= '0;
      col_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      row_q         <= row_d;
      col_q         <= col_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q     <= stage_d;
      stage_col_q <= col_q;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;
  assign stage_col_o   = stage_col_q;
  assign ram_re_o      = accept && live;
  assign ram_raddr_o   = col_q;

endmodule

`default_nettype wire

>>> design/bm3_window.sv
`default_nettype none

module bm3_window
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int ColW = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              morph_mode_i,
  input  wire logic [7:0]        bright_threshold_i,
  input  wire logic              stage_valid_i,
  input  wire stage_t            stage_i,
  input  wire logic [ColW-1:0]   stage_col_i,
  input  wire logic [LINE_W-1:0] ram_rdata_i,
  output logic                   adv_o,
  output logic                   ram_we_o,
  output logic      [ColW-1:0]   ram_waddr_o,
  output logic      [LINE_W-1:0] ram_wdata_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [7:0]        red_out_o,
  output logic      [7:0]        green_out_o,
  output logic      [7:0]        blue_out_o,
  output logic                   frame_end_o
);

  col_cls_t   s0_q, s1_q, new_col, left_col, ctr_col, right_col;
  logic [1:0] cls_new;
  logic [7:0] nb_above, nb_below;
  logic       any_above, any_below, fg, fire;
  logic       out_valid_q, out_valid_d;
  logic       fg_q, last_q;

  assign cls_new = bright_class(stage_i.red, stage_i.green, stage_i.blue,
                                bright_threshold_i);

  // Line buffer holds {row-2, row-1}; rows clamp at the top and bottom.
  always_comb begin
    new_col.mid = ram_rdata_i[1:0];
    new_col.top = stage_i.top_clamp ? ram_rdata_i[1:0] : ram_rdata_i[3:2];
    new_col.bot = stage_i.bot_clamp ? ram_rdata_i[1:0] : cls_new;
  end

  always_comb begin
    case (stage_i.sel)
      WIN_ROW_START: begin
        // last column of the previous row: right neighbor clamps to center
        left_col  = s0_q;
        ctr_col   = s1_q;
        right_col = s1_q;
      end
      WIN_COL_ONE: begin
        left_col  = s1_q;
        ctr_col   = s1_q;
        right_col = new_col;
      end
      default: begin
        left_col  = s0_q;
        ctr_col   = s1_q;
        right_col = new_col;
      end
    endcase
  end

  always_comb begin
    nb_above = {left_col.top[CLS_ABOVE_BIT], left_col.mid[CLS_ABOVE_BIT],
                left_col.bot[CLS_ABOVE_BIT], ctr_col.top[CLS_ABOVE_BIT],
                ctr_col.bot[CLS_ABOVE_BIT], right_col.top[CLS_ABOVE_BIT],
                right_col.mid[CLS_ABOVE_BIT], right_col.bot[CLS_ABOVE_BIT]};
    nb_below = {left_col.top[CLS_BELOW_BIT], left_col.mid[CLS_BELOW_BIT],
                left_col.bot[CLS_BELOW_BIT], ctr_col.top[CLS_BELOW_BIT],
                ctr_col.bot[CLS_BELOW_BIT], right_col.top[CLS_BELOW_BIT],
                right_col.mid[CLS_BELOW_BIT], right_col.bot[CLS_BELOW_BIT]};
  end

  assign any_above = |nb_above;
  assign any_below = |nb_below;
  assign fg = (morph_mode_i == MODE_ERODE) ? !any_below : any_above;

  assign adv_o = !stage_i.emit || !out_valid_q || out_ready_i;
  assign fire  = stage_valid_i && adv_o;

  assign ram_we_o    = fire && stage_i.pix;
  assign ram_waddr_o = stage_col_i;
  assign ram_wdata_o = {new_col.mid, cls_new};

  always_comb begin
    if (fire && stage_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s0_q <= s1_q;
      s1_q <= new_col;
    end
    if (fire && stage_i.emit) begin
      fg_q   <= fg;
      last_q <= stage_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = fg_q ? FG_RED : '0;
  assign green_out_o = fg_q ? FG_GREEN : '0;
  assign blue_out_o  = fg_q ? FG_BLUE : '0;
  assign frame_end_o = last_q;

endmodule

`default_nettype wire

>>> design/binary_morphology_3x3_core.sv
// Binary 3x3 dilate/erode over a raster-order RGB pixel stream.
// Input channel (in_valid_i/in_ready_o): one beat per pixel (cmd_i = 0)
// or one drain beat (cmd_i = 1). Each pixel is classed above/below/equal
// against bright_threshold using max(R,G,B). Output channel
// (out_valid_o/out_ready_i): one beat per result pixel, pink or black,
// frame_end_o set on the last pixel of the frame.
// Results lag the input stream by one row plus one pixel; after the last
// pixel of a frame, width+1 drain beats flush the remaining results.
// Pixels after frame input is complete, and drains before it, are
// swallowed with no result.
// Throughput: one beat per clock unless the output stalls. A result is
// offered once its beat has passed the stage and then the output register.
// The line buffer is one MAX_WIDTH x 4-bit RAM (two previous rows of
// classes), read per unswallowed beat and written per unswallowed pixel.
// A stalled output holds its beat; the stage behind it keeps taking beats
// that produce no result, and stalls the input only when a second result
// would be waiting.
// Reset: 640x480, dilate, threshold 127; position counters clear. The line
// buffer is not cleared; stale entries are masked by the top-row clamp.
// Config (APB, regs at 0x0/0x4/0x8/0xC): write only while idle, unenforced.
`default_nettype none

module binary_morphology_3x3_core
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // input beats
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [7:0]         red_in_i,
  input  wire logic [7:0]         green_in_i,
  input  wire logic [7:0]         blue_in_i,
  // result beats
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [7:0]         red_out_o,
  output logic      [7:0]         green_out_o,
  output logic      [7:0]         blue_out_o,
  output logic                    frame_end_o
);

  localparam int ColW = $clog2(MAX_WIDTH);

  cfg_t              cfg;
  stage_t            stage;
  logic              stage_valid;
  logic [ColW-1:0]   stage_col;
  logic              adv;
  logic              ram_re, ram_we;
  logic [ColW-1:0]   ram_raddr, ram_waddr;
  logic [LINE_W-1:0] ram_rdata, ram_wdata;

  bm3_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Position tracking, item filtering and the stage register.
  bm3_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .adv_i         (adv),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .stage_col_o   (stage_col),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  // Two rows of pixel classes, one entry per column.
  bm3_ram #(
    .Width (LINE_W),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Column window, neighbor test and the output register.
  bm3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .morph_mode_i       (cfg.morph_mode),
    .bright_threshold_i (cfg.bright_threshold),
    .stage_valid_i      (stage_valid),
    .stage_i            (stage),
    .stage_col_i        (stage_col),
    .ram_rdata_i        (ram_rdata),
    .adv_o              (adv),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .red_out_o          (red_out_o),
    .green_out_o        (green_out_o),
    .blue_out_o         (blue_out_o),
    .frame_end_o        (frame_end_o)
  );

endmodule

`default_nettype wire

>>> design/bm3_checker.sv
`default_nettype none
`include "binary_morphology_3x3_core_assert.svh"

module bm3_checker
  import bm3_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_out_o,
  input wire logic [7:0] green_out_o,
  input wire logic [7:0] blue_out_o,
  input wire logic       frame_end_o
);

  // A stalled result beat stays offered.
  `BM3_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")

  // A stalled result beat keeps its payload.
  `BM3_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_end_o), "result payload changed while stalled")

  // Results are either all-black or the fixed foreground color.
  `BM3_ASSERT_IMP(a_out_color, clk_i, rst_ni, out_valid_o, (red_out_o == 8'd0 && green_out_o == 8'd0 && blue_out_o == 8'd0) || (red_out_o == FG_RED && green_out_o == FG_GREEN && blue_out_o == FG_BLUE), "result color is neither black nor foreground")

  // With no result waiting, the input side is never held off.
  `BM3_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output register")

endmodule

bind binary_morphology_3x3_core bm3_checker u_bm3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o),
  .frame_end_o (frame_end_o)
);

`default_nettype wire
